// File: sv/mscdt_pkg.sv
// ----------------------------------------------------------------------------
// mscdt_pkg: shared definitions for the multi-slot countdown timer
// Operation codes, field widths, controller states and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mscdt_pkg;

	localparam int SLOTS_DEF = 16;

	localparam int OP_W    = 3;
	localparam int SLOT_W  = 4;
	localparam int COUNT_W = 32;
	localparam int TAG_W   = 32;

	// Input word: operation, slot, reload, count, tag from the lowest bit up.
	localparam int IN_TDATA_W  = 72;
	// Output word: expired_slot, expired_tag, then zero padding.
	localparam int OUT_TDATA_W = 40;

	localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
	localparam logic [OP_W-1:0] OP_CREATE = 3'd1;
	localparam logic [OP_W-1:0] OP_START  = 3'd2;
	localparam logic [OP_W-1:0] OP_MODIFY = 3'd3;
	localparam logic [OP_W-1:0] OP_CLOSE  = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FLUSH
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic apply_op;    // apply a non-tick operation from the input word
		logic walk_start;  // tick accepted: issue the read of slot 0
		logic walk_step;   // commit the slot under evaluation, move on
		logic flush_push;  // hand the held expiry on as the final one
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic step_ok;     // the slot under evaluation can commit now
		logic at_end;      // the slot under evaluation is the last one
		logic pend_vld;    // an expiry is held back, waiting for its last flag
		logic out_free;    // the output register can take a word this cycle
	} stat_t;

endpackage

`default_nettype wire

// File: sv/mscdt_ctrl.sv
// ----------------------------------------------------------------------------
// mscdt_ctrl: sequencing controller
// Accepts input words, launches the slot walk of a tick and closes it off.
// ----------------------------------------------------------------------------
`default_nettype none

module mscdt_ctrl (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	input  wire  [mscdt_pkg::OP_W-1:0]   op,
	input  mscdt_pkg::stat_t             stat,
	output mscdt_pkg::cmd_t              cmd
);
	import mscdt_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   accept;

	assign accept = s_tvalid && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (op == OP_TICK)) begin
					state_nxt = ST_WALK;
				end
			end
			ST_WALK: begin
				if (stat.step_ok && stat.at_end) begin
					state_nxt = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!stat.pend_vld || stat.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready       = 1'b0;
		cmd            = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready       = 1'b1;
				cmd.walk_start = accept && (op == OP_TICK);
				cmd.apply_op   = accept && (op != OP_TICK);
			end
			ST_WALK: begin
				cmd.walk_step = stat.step_ok;
			end
			ST_FLUSH: begin
				cmd.flush_push = stat.pend_vld && stat.out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

`ifndef SYNTHESIS
	// A walk always ends in the flush state before new words are taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) && stat.step_ok && stat.at_end |=> (state_q == ST_FLUSH))
		else $error("walk did not end in flush");

	// The flush state never lasts beyond the moment the held expiry can go.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) && (!stat.pend_vld || stat.out_free) |=> (state_q == ST_IDLE))
		else $error("flush did not return to idle");

	// No word is taken while a walk is under way.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> !s_tready)
		else $error("input ready during walk");
`endif

endmodule

`default_nettype wire

// File: sv/mscdt_dp.sv
// ----------------------------------------------------------------------------
// mscdt_dp: timer table datapath
// Slot flags, count, period and tag stores, the countdown unit (one slot a
// cycle unless stalled), the held-back expiry and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mscdt_dp #(
	parameter int SLOTS = mscdt_pkg::SLOTS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  mscdt_pkg::cmd_t                  cmd,
	output mscdt_pkg::stat_t                 stat,
	input  wire  [mscdt_pkg::OP_W-1:0]       op,
	input  wire  [mscdt_pkg::SLOT_W-1:0]     slot,
	input  wire                              reload,
	input  wire  [mscdt_pkg::COUNT_W-1:0]    count,
	input  wire  [mscdt_pkg::TAG_W-1:0]      tag,
	output logic                             out_vld,
	input  wire                              out_rdy,
	output logic [mscdt_pkg::SLOT_W-1:0]     expired_slot,
	output logic [mscdt_pkg::TAG_W-1:0]      expired_tag,
	output logic                             last
);
	import mscdt_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	// Count, period and tag stores: one write port, one registered read port.
	logic [COUNT_W-1:0] rem_mem [SLOTS];
	logic [COUNT_W-1:0] per_mem [SLOTS];
	logic [TAG_W-1:0]   tag_mem [SLOTS];

	logic [SLOTS-1:0] in_use_q;
	logic [SLOTS-1:0] armed_q;
	logic [SLOTS-1:0] periodic_q;

	logic [IW-1:0]      idx_q;
	logic [IW-1:0]      rd_addr;
	logic               rd_en;
	logic [COUNT_W-1:0] rem_rd_q;
	logic [COUNT_W-1:0] per_rd_q;
	logic [TAG_W-1:0]   tag_rd_q;

	logic               pend_vld_q;
	logic [SLOT_W-1:0]  pend_slot_q;
	logic [TAG_W-1:0]   pend_tag_q;

	logic               out_vld_q;
	logic [SLOT_W-1:0]  out_slot_q;
	logic [TAG_W-1:0]   out_tag_q;
	logic               out_last_q;

	logic [IW-1:0]      op_addr;
	logic               slot_ok;
	logic               at_end;
	logic               active;
	logic [COUNT_W-1:0] dec;
	logic               expire;
	logic               out_free;
	logic               step_push;
	logic               rem_we;
	logic [IW-1:0]      rem_wa;
	logic [COUNT_W-1:0] rem_wd;
	logic [SLOTS-1:0]   in_use_cl;

	assign op_addr = IW'(slot);
	assign slot_ok = ({28'd0, slot} < 32'(SLOTS));
	assign at_end  = (idx_q == IW'(SLOTS - 1));

	// Countdown of the slot under evaluation.
	assign active = in_use_q[idx_q] && armed_q[idx_q];
	assign dec    = rem_rd_q - COUNT_W'(1);
	assign expire = active && (dec == '0);

	assign out_free  = !out_vld_q || out_rdy;
	assign step_push = cmd.walk_step && expire && pend_vld_q;

	assign stat.step_ok  = !(expire && pend_vld_q && !out_free);
	assign stat.at_end   = at_end;
	assign stat.pend_vld = pend_vld_q;
	assign stat.out_free = out_free;

	// Read the slot after the one now under evaluation; slot 0 on a walk start or last step.
	always_comb begin
		rd_en   = cmd.walk_start || cmd.walk_step;
		rd_addr = '0;
		if (cmd.walk_step && !at_end) begin
			rd_addr = idx_q + IW'(1);
		end
	end

	// Write port of the count store: operations in idle, countdown in a walk.
	always_comb begin
		rem_we = 1'b0;
		rem_wa = op_addr;
		rem_wd = count;
		if (cmd.apply_op && slot_ok && (op == OP_CREATE)) begin
			rem_we = 1'b1;
		end else if (cmd.apply_op && slot_ok && (op == OP_MODIFY)) begin
			rem_we = 1'b1;
			rem_wd = count + COUNT_W'(1);
		end else if (cmd.walk_step && active) begin
			rem_we = 1'b1;
			rem_wa = idx_q;
			rem_wd = (expire && periodic_q[idx_q]) ? per_rd_q : dec;
		end
	end

	always_ff @(posedge clk) begin
		if (rem_we) begin
			rem_mem[rem_wa] <= rem_wd;
		end
		if (cmd.apply_op && slot_ok && (op == OP_CREATE)) begin
			per_mem[op_addr] <= count;
			tag_mem[op_addr] <= tag;
		end
		if (rd_en) begin
			rem_rd_q <= rem_mem[rd_addr];
			per_rd_q <= per_mem[rd_addr];
			tag_rd_q <= tag_mem[rd_addr];
		end
	end

	always_comb begin
		in_use_cl          = in_use_q;
		in_use_cl[op_addr] = 1'b0;
	end

	// Slot flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q   <= '0;
			armed_q    <= '0;
			periodic_q <= '0;
		end else if (cmd.apply_op && slot_ok) begin
			unique case (op)
				OP_CREATE: begin
					periodic_q[op_addr] <= reload;
					armed_q[op_addr]    <= 1'b0;
					in_use_q[op_addr]   <= 1'b1;
				end
				OP_START: begin
					armed_q[op_addr] <= 1'b1;
				end
				OP_MODIFY: begin
					in_use_q[op_addr] <= 1'b1;
				end
				OP_CLOSE: begin
					in_use_q <= in_use_cl;
					armed_q  <= armed_q & in_use_cl;
				end
				default: begin
					in_use_q <= in_use_q;
				end
			endcase
		end else if (cmd.walk_step && expire && !periodic_q[idx_q]) begin
			in_use_q[idx_q] <= 1'b0;
		end
	end

	// Walk index: the slot whose data sits in the read registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.walk_start) begin
			idx_q <= '0;
		end else if (cmd.walk_step) begin
			idx_q <= rd_addr;
		end
	end

	// One expiry is held back until the next one, or the walk end, settles last.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
		end else if (cmd.walk_step && expire) begin
			pend_vld_q <= 1'b1;
		end else if (cmd.flush_push) begin
			pend_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_step && expire) begin
			pend_slot_q <= SLOT_W'(idx_q);
			pend_tag_q  <= tag_rd_q;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (step_push || cmd.flush_push) begin
			out_vld_q <= 1'b1;
		end else if (out_rdy) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_push || cmd.flush_push) begin
			out_slot_q <= pend_slot_q;
			out_tag_q  <= pend_tag_q;
			out_last_q <= cmd.flush_push;
		end
	end

	assign out_vld      = out_vld_q;
	assign expired_slot = out_slot_q;
	assign expired_tag  = out_tag_q;
	assign last         = out_last_q;

`ifndef SYNTHESIS
	// A word is never loaded over one that has not been taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		(step_push || cmd.flush_push) |-> out_free)
		else $error("output register overwritten");

	// The closing push only happens with an expiry held back.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush_push |-> pend_vld_q)
		else $error("flush without held expiry");

	// After the closing push nothing is left held back.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush_push |=> !pend_vld_q)
		else $error("held expiry survived the flush");

	// Operations and walk steps never share a cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.apply_op && (cmd.walk_step || cmd.walk_start || cmd.flush_push)))
		else $error("operation during walk");
`endif

endmodule

`default_nettype wire

// File: sv/multi_slot_countdown_timer_top.sv
// ----------------------------------------------------------------------------
// multi_slot_countdown_timer_top: table of countdown timers
// Create, start, modify and close timer slots; a tick counts every running
// slot down and reports the slots that reach zero.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Word contents (lowest bit first)
//  s_*       in         operation[3], slot[4], reload[1], count[32], tag[32]
//  m_*       out        expired_slot[4], expired_tag[32], pad[4]; m_tlast = last
//
// A create, start, modify or close word is applied as it is accepted. A tick
// is accepted with the read of slot 0, walks every slot through the single
// countdown unit and ends in a closing step that hands on the final expiry.
// The count, period and tag stores have one read port each, which sets the
// rate of one slot per cycle. A stalled output holds the walk when a second
// expiry needs the output register while it is still full, and holds the
// closing step until the register is free. Reset clears the slot flags; the
// stores are not cleared and no clearing pass runs after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_slot_countdown_timer_top #(
	parameter int SLOTS = mscdt_pkg::SLOTS_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  s_tvalid,
	output logic                                 s_tready,
	// operation[2:0], slot[6:3], reload[7], count[39:8], tag[71:40]
	input  wire  [mscdt_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                                 m_tvalid,
	input  wire                                  m_tready,
	// expired_slot[3:0], expired_tag[35:4], zero padding[39:36]
	output logic [mscdt_pkg::OUT_TDATA_W-1:0]    m_tdata,
	output logic                                 m_tlast
);
	import mscdt_pkg::*;

	cmd_t               cmd;
	stat_t              stat;
	logic [OP_W-1:0]    op;
	logic [SLOT_W-1:0]  slot;
	logic               reload;
	logic [COUNT_W-1:0] count;
	logic [TAG_W-1:0]   tag;
	logic [SLOT_W-1:0]  expired_slot;
	logic [TAG_W-1:0]   expired_tag;

	// Unpack the input word.
	assign op     = s_tdata[2:0];
	assign slot   = s_tdata[6:3];
	assign reload = s_tdata[7];
	assign count  = s_tdata[39:8];
	assign tag    = s_tdata[71:40];

	// The controller takes words only when idle and steps the slot walk.
	mscdt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.op       (op),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds the table, the countdown unit and the output register.
	mscdt_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.op           (op),
		.slot         (slot),
		.reload       (reload),
		.count        (count),
		.tag          (tag),
		.out_vld      (m_tvalid),
		.out_rdy      (m_tready),
		.expired_slot (expired_slot),
		.expired_tag  (expired_tag),
		.last         (m_tlast)
	);

	// Pack the output word, padded with zeros to whole bytes.
	assign m_tdata = {4'd0, expired_tag, expired_slot};

endmodule

`default_nettype wire

// File: tb/multi_slot_countdown_timer_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_slot_countdown_timer_top_test: self-checking bench for the timer table
// Drives command words through the input stream and checks every expiry word
// against a behavioural timer table kept alongside the block, or against the
// hand-written expiry of a fixed row. A short hand-written table of words opens
// the run, and random traffic follows. Both stream sides idle at random.
// ----------------------------------------------------------------------------

module multi_slot_countdown_timer_top_test;

	import mscdt_pkg::*;

	localparam int CLK_PERIOD    = 8;
	localparam int RESET_CYCLES  = 7;
	localparam int N_SLOTS       = SLOTS_DEF;
	// The slowest correct run is 150 words, each with at most a random gap, a walk
	// and up to 16 expiries that may each wait out an output stall. The limit
	// leaves a wide margin over that.
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int RANDOM_WORDS  = 125;
	// Settle time after the last expiry; its margin also covers a stalled output.
	localparam int SETTLE_CYCLES = 4 * (N_SLOTS + 2);

	// These operation codes are not decoded by the block and must be ignored.
	localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
	localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

	localparam logic [TAG_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [SLOT_W-1:0]  slot;
		logic               reload;
		logic [COUNT_W-1:0] count;
		logic [TAG_W-1:0]   tag;
	} timer_cmd_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [TAG_W-1:0]  tag;
		logic              last;
	} expiry_t;

	// One directed row. Where fixed is set, the expiry is written out by hand:
	// none if hit is clear, otherwise a single word for hit_slot and hit_tag.
	typedef struct packed {
		timer_cmd_t        cmd;
		logic              fixed;
		logic              hit;
		logic [SLOT_W-1:0] hit_slot;
		logic [TAG_W-1:0]  hit_tag;
	} dir_row_t;

	localparam dir_row_t DIRECTED [0:24] = '{
		// A tick straight after reset: nothing is running.
		'{'{OP_TICK,   4'd0,  1'b0, 32'd0, 32'd0},              1'b1, 1'b0, 4'd0, 32'd0},
		'{'{OP_CREATE, 4'd0,  1'b0, 32'd1, ALL_ONES},           1'b0, 1'b0, 4'd0, 32'd0},
		// A created slot stays stopped until it is started.
		'{'{OP_TICK,   4'd0,  1'b0, 32'd0, 32'd0},              1'b1, 1'b0, 4'd0, 32'd0},
		'{'{OP_START,  4'd0,  1'b0, 32'd0, 32'd0},              1'b0, 1'b0, 4'd0, 32'd0},
		'{'{OP_TICK,   4'd0,  1'b0, 32'd0, 32'd0},              1'b1, 1'b1, 4'd0, ALL_ONES},
		// The one-shot slot is still armed, so a modify alone revives it.
		'{'{OP_MODIFY, 4'd0,  1'b0, 32'd0, 32'd0},              1'b0, 1'b0, 4'd0, 32'd0},
		'{'{OP_TICK,   4'd0,  1'b0, 32'd0, 32'd0},              1'b1, 1'b1, 4'd0, ALL_ONES},
		'{'{OP_CREATE, 4'd15, 1'b1, 32'd2, 32'd0},              1'b0, 1'b0, 4'd0, 32'd0},
		'{'{OP_START,  4'd15, 1'b0, 32'd0, 32'd0},              1'b0, 1'b0, 4'd0, 32'd0},
		'{'{OP_CREATE, 4'd7,  1'b1, 32'd1, 32'hA5A5_5A5A},      1'b0, 1'b0, 4'd0, 32'd0},
		'{'{OP_START,  4'd7,  1'b0, 32'd0, 32'd0},              1'b0, 1'b0, 4'd0, 32'd0},
		'{'{OP_TICK,   4'd0,  1'b0, 32'd0, 32'd0},              1'b0, 1'b0, 4'd0, 32'd0},
		'{'{OP_TICK,   4'd0,  1'b0, 32'd0, 32'd0},              1'b0, 1'b0, 4'd0, 32'd0},
		// A close of an idle slot also disarms the expired slot 0.
		'{'{OP_CLOSE,  4'd3,  1'b0, 32'd0, 32'd0},              1'b0, 1'b0, 4'd0, 32'd0},
		'{'{OP_MODIFY, 4'd0,  1'b0, 32'd2, 32'd0},              1'b0, 1'b0, 4'd0, 32'd0},
		// Starting a slot that is not in use only arms it.
		'{'{OP_START,  4'd9,  1'b0, 32'd0, 32'd0},              1'b0, 1'b0, 4'd0, 32'd0},
		// A zero count wraps on its first tick instead of expiring.
		'{'{OP_CREATE, 4'd1,  1'b0, 32'd0, 32'h1234_5678},      1'b0, 1'b0, 4'd0, 32'd0},
		'{'{OP_START,  4'd1,  1'b0, 32'd0, 32'd0},              1'b0, 1'b0, 4'd0, 32'd0},
		'{'{OP_TICK,   4'd0,  1'b0, 32'd0, 32'd0},              1'b0, 1'b0, 4'd0, 32'd0},
		'{'{OP_MODIFY, 4'd1,  1'b0, ALL_ONES, 32'd0},           1'b0, 1'b0, 4'd0, 32'd0},
		'{'{OP_TICK,   4'd0,  1'b0, 32'd0, 32'd0},              1'b0, 1'b0, 4'd0, 32'd0},
		'{'{OP_RSVD7,  4'd15, 1'b1, ALL_ONES, ALL_ONES},        1'b0, 1'b0, 4'd0, 32'd0},
		'{'{OP_RSVD5,  4'd7,  1'b0, 32'd0, 32'd0},              1'b0, 1'b0, 4'd0, 32'd0},
		'{'{OP_CLOSE,  4'd15, 1'b0, 32'd0, 32'd0},              1'b0, 1'b0, 4'd0, 32'd0},
		'{'{OP_TICK,   4'd0,  1'b0, 32'd0, 32'd0},              1'b0, 1'b0, 4'd0, 32'd0}
	};

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;

	multi_slot_countdown_timer_top #(
		.SLOTS(N_SLOTS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	// Behavioural copy of the timer table.
	bit                 tm_in_use   [N_SLOTS];
	bit                 tm_armed    [N_SLOTS];
	bit                 tm_periodic [N_SLOTS];
	bit                 tm_created  [N_SLOTS];
	logic [COUNT_W-1:0] tm_period   [N_SLOTS];
	logic [COUNT_W-1:0] tm_remaining[N_SLOTS];
	logic [TAG_W-1:0]   tm_tag      [N_SLOTS];

	expiry_t tick_expiries[$];   // expiries of the word just accepted
	expiry_t pending_expiries[$];  // expiry words still to arrive

	int                burst_left;
	logic [SLOT_W-1:0] recent_slot;
	int                n_words;
	int                n_ticks;
	int                n_random;
	int                n_expiries_due;
	int                n_expiries_seen;
	int                n_errors;
	int                n_cycles;
	logic [15:0]       ready_pattern;
	int                pattern_age;

	initial begin
		clk = 1'b0;
	end

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Applies one accepted command word to the table. A tick leaves its
	// expiries in tick_expiries, in ascending slot order, with the final one
	// marked as last.
	function automatic void advance_timers(input timer_cmd_t c);
		tick_expiries.delete();
		case (c.op)
			OP_TICK: begin
				for (int i = 0; i < N_SLOTS; i++) begin
					if (tm_in_use[i] && tm_armed[i]) begin
						tm_remaining[i] = tm_remaining[i] - 1'b1;
						if (tm_remaining[i] == '0) begin
							if (tm_periodic[i])
								tm_remaining[i] = tm_period[i];
							else
								tm_in_use[i] = 1'b0;
							tick_expiries.push_back('{slot: SLOT_W'(i), tag: tm_tag[i],
								last: 1'b0});
						end
					end
				end
				if (tick_expiries.size() > 0)
					tick_expiries[tick_expiries.size() - 1].last = 1'b1;
			end
			OP_CREATE: begin
				tm_periodic[c.slot]  = c.reload;
				tm_period[c.slot]    = c.count;
				tm_remaining[c.slot] = c.count;
				tm_tag[c.slot]       = c.tag;
				tm_armed[c.slot]     = 1'b0;
				tm_in_use[c.slot]    = 1'b1;
				tm_created[c.slot]   = 1'b1;
			end
			OP_START: tm_armed[c.slot] = 1'b1;
			OP_MODIFY: begin
				tm_remaining[c.slot] = c.count + 1'b1;
				tm_in_use[c.slot]    = 1'b1;
			end
			OP_CLOSE: begin
				tm_in_use[c.slot] = 1'b0;
				for (int i = 0; i < N_SLOTS; i++)
					if (!tm_in_use[i])
						tm_armed[i] = 1'b0;
			end
			default: ;
		endcase
	endfunction

	// Counts are mostly small so that slots expire often. Now and then a count
	// is all ones or fully random, and the bits of the field all get exercised.
	function automatic logic [COUNT_W-1:0] random_count();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 6)
			return ALL_ONES;
		if (pick < 12)
			return $urandom;
		return $urandom_range(0, 4);
	endfunction

	// Random words are weighted towards create, start and tick on the same
	// slots, so that most of the traffic runs the timers down to expiry.
	// A modify only targets a slot that has been created, because a modify on
	// any other slot would read period and tag entries that were never written.
	function automatic timer_cmd_t random_cmd();
		timer_cmd_t c;
		int         pick;
		int         first;
		logic [SLOT_W-1:0] s;
		pick = $urandom_range(0, 99);
		c = '{op: OP_TICK, slot: SLOT_W'($urandom), reload: 1'($urandom),
			count: $urandom, tag: $urandom};
		if (pick < 38) begin
			c.op = OP_TICK;
		end else if (pick < 58) begin
			c.op = OP_CREATE;
			c.count = random_count();
			recent_slot = c.slot;
		end else if (pick < 76) begin
			c.op = OP_START;
			if ($urandom_range(0, 9) < 6)
				c.slot = recent_slot;
		end else if (pick < 86) begin
			c.op = OP_TICK;
			first = $urandom_range(0, N_SLOTS - 1);
			for (int k = 0; k < N_SLOTS; k++) begin
				s = SLOT_W'((first + k) % N_SLOTS);
				if (c.op == OP_TICK && tm_created[s]) begin
					c.op = OP_MODIFY;
					c.slot = s;
					c.count = random_count();
				end
			end
		end else if (pick < 96) begin
			c.op = OP_CLOSE;
		end else begin
			c.op = OP_W'($urandom_range(OP_RSVD5, OP_RSVD7));
		end
		return c;
	endfunction

	// Presents one command word from a falling edge and waits for it to be
	// taken. The sender runs in bursts; before each burst it may drop tvalid
	// for a random gap. Expectations are queued at the accepting edge.
	task automatic send_word(input timer_cmd_t c, input logic fixed, input logic hit,
		input logic [SLOT_W-1:0] hit_slot, input logic [TAG_W-1:0] hit_tag);
		int gap;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 20);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		s_tdata  <= {c.tag, c.count, c.reload, c.slot, c.op};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		advance_timers(c);
		if (fixed) begin
			if (hit)
				pending_expiries.push_back('{slot: hit_slot, tag: hit_tag, last: 1'b1});
		end else begin
			foreach (tick_expiries[k])
				pending_expiries.push_back(tick_expiries[k]);
		end
		n_expiries_due += fixed ? int'(hit) : tick_expiries.size();
		n_words++;
		if (c.op == OP_TICK)
			n_ticks++;
		burst_left--;
		@(negedge clk);
	endtask

	// The receiver follows a rotating 16-bit ready pattern. The pattern is
	// replaced every so often, and about a quarter of the patterns never stall.
	always @(negedge clk) begin
		if (pattern_age <= 0) begin
			pattern_age = $urandom_range(40, 160);
			if ($urandom_range(0, 3) == 0)
				ready_pattern = 16'hFFFF;
			else
				ready_pattern = 16'($urandom) | 16'h0001;
		end
		pattern_age--;
		m_tready <= ready_pattern[0];
		ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
	end

	// Every accepted expiry word is checked against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			n_expiries_seen++;
			if (pending_expiries.size() == 0) begin
				$error("unexpected expiry word: slot %0d tag %h",
					m_tdata[SLOT_W-1:0], m_tdata[SLOT_W +: TAG_W]);
				n_errors++;
			end else begin
				if (m_tdata[SLOT_W-1:0] !== pending_expiries[0].slot) begin
					$error("expired_slot: expected %0d, got %0d",
						pending_expiries[0].slot, m_tdata[SLOT_W-1:0]);
					n_errors++;
				end
				if (m_tdata[SLOT_W +: TAG_W] !== pending_expiries[0].tag) begin
					$error("expired_tag: expected %h, got %h",
						pending_expiries[0].tag, m_tdata[SLOT_W +: TAG_W]);
					n_errors++;
				end
				if (m_tlast !== pending_expiries[0].last) begin
					$error("last: expected %0b, got %0b", pending_expiries[0].last, m_tlast);
					n_errors++;
				end
				void'(pending_expiries.pop_front());
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d expiries outstanding.",
				n_cycles, pending_expiries.size());
			$display("multi_slot_countdown_timer_top regression: fail");
			$finish;
		end
	end

	initial begin
		timer_cmd_t c;
		arst_n          = 1'b0;
		s_tvalid        = 1'b0;
		s_tdata         = '0;
		m_tready        = 1'b0;
		ready_pattern   = 16'hFFFF;
		pattern_age     = 0;
		burst_left      = 0;
		recent_slot     = '0;
		n_words         = 0;
		n_ticks         = 0;
		n_random        = 0;
		n_expiries_due  = 0;
		n_expiries_seen = 0;
		n_errors        = 0;
		n_cycles        = 0;
		for (int i = 0; i < N_SLOTS; i++) begin
			tm_in_use[i]   = 1'b0;
			tm_armed[i]    = 1'b0;
			tm_periodic[i] = 1'b0;
			tm_created[i]  = 1'b0;
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (DIRECTED[r])
			send_word(DIRECTED[r].cmd, DIRECTED[r].fixed, DIRECTED[r].hit,
				DIRECTED[r].hit_slot, DIRECTED[r].hit_tag);

		while (n_random < RANDOM_WORDS) begin
			c = random_cmd();
			send_word(c, 1'b0, 1'b0, '0, '0);
			n_random++;
		end
		s_tvalid <= 1'b0;

		while (pending_expiries.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d command words (%0d ticks); checked %0d of %0d expiry words.",
			n_words, n_ticks, n_expiries_seen, n_expiries_due);
		$display("The input side ran in bursts with gaps, and the output side stalled.");
		if (n_errors == 0)
			$display("multi_slot_countdown_timer_top regression: pass");
		else
			$display("multi_slot_countdown_timer_top regression: fail");
		$finish;
	end

endmodule
